>>> hw/rtl/dqvcl_pkg.sv
// shared widths, register codes, pipeline records and the square root step
package dqvcl_pkg;

	localparam int VOLT_WIDTH      = 16;
	localparam int REG_WIDTH       = 16;
	localparam int CIRCLE_WIDTH    = 15;
	localparam int CFG_DATA_WIDTH  = 16;
	localparam int CFG_INDEX_WIDTH = 2;

	localparam int CMP_WIDTH  = (VOLT_WIDTH > REG_WIDTH) ? VOLT_WIDTH : REG_WIDTH;
	localparam int RAD_WIDTH  = 2 * CMP_WIDTH;
	localparam int ROOT_WIDTH = CMP_WIDTH;
	localparam int REM_WIDTH  = CMP_WIDTH + 1;
	localparam int TRY_WIDTH  = CMP_WIDTH + 3;
	localparam int C2_WIDTH   = 2 * CIRCLE_WIDTH;
	localparam int ROOT_STAGES = ROOT_WIDTH;

	localparam logic signed [REG_WIDTH-1:0] TORQUE_MAX_RESET = REG_WIDTH'(200);
	localparam logic signed [REG_WIDTH-1:0] FLUX_MIN_RESET   = -REG_WIDTH'(5);
	localparam logic [CIRCLE_WIDTH-1:0]     CIRCLE_MAX_RESET = CIRCLE_WIDTH'(200);

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_TORQUE_MAX = 2'd0,
		REG_FLUX_MIN   = 2'd1,
		REG_CIRCLE_MAX = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic signed [CMP_WIDTH-1:0] qc;
		logic                        zero;
	} side_t;

	typedef struct packed {
		logic [RAD_WIDTH-1:0] sum;
		logic [RAD_WIDTH-1:0] diff;
		side_t                side;
	} root_in_t;

	typedef struct packed {
		logic [ROOT_WIDTH-1:0] mag;
		logic [ROOT_WIDTH-1:0] qroot;
		side_t                 side;
	} root_out_t;

	typedef struct packed {
		logic [RAD_WIDTH-1:0]  rad;
		logic [REM_WIDTH-1:0]  rem;
		logic [ROOT_WIDTH-1:0] root;
	} root_state_t;

	// one result bit of the digit recurrence
	function automatic root_state_t root_step(input root_state_t s);
		logic [TRY_WIDTH-1:0] sh;
		logic [TRY_WIDTH-1:0] tr;
		root_state_t          r;
		sh = {s.rem, s.rad[RAD_WIDTH-1 -: 2]};
		tr = {1'b0, s.root, 2'b01};
		r.rad = {s.rad[RAD_WIDTH-3:0], 2'b00};
		if (sh >= tr) begin
			r.rem  = REM_WIDTH'(sh - tr);
			r.root = {s.root[ROOT_WIDTH-2:0], 1'b1};
		end else begin
			r.rem  = REM_WIDTH'(sh);
			r.root = {s.root[ROOT_WIDTH-2:0], 1'b0};
		end
		return r;
	endfunction

endpackage

>>> hw/rtl/dqvcl_if.sv
// request and result channel interfaces
interface dqvcl_in_if;
	logic                                     valid;
	logic                                     ready;
	logic signed [dqvcl_pkg::VOLT_WIDTH-1:0] volt_q;
	logic signed [dqvcl_pkg::VOLT_WIDTH-1:0] volt_d;

	modport source(output valid, output volt_q, output volt_d, input ready);
	modport sink(input valid, input volt_q, input volt_d, output ready);
endinterface

interface dqvcl_out_if;
	logic                                     valid;
	logic                                     ready;
	logic signed [dqvcl_pkg::VOLT_WIDTH-1:0] q_limited;
	logic [dqvcl_pkg::VOLT_WIDTH-1:0]        magnitude;
	logic                                     circle_hit;

	modport source(output valid, output q_limited, output magnitude, output circle_hit,
		input ready);
	modport sink(input valid, input q_limited, input magnitude, input circle_hit,
		output ready);
endinterface

>>> hw/rtl/dqvcl_root_pipe.sv
// twin pipelined integer square roots, one result bit per stage
module dqvcl_root_pipe (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  dqvcl_pkg::root_in_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output dqvcl_pkg::root_out_t out_data
);

	logic [dqvcl_pkg::ROOT_STAGES-1:0] v_q;
	logic [dqvcl_pkg::ROOT_STAGES-1:0] v_in;
	logic [dqvcl_pkg::ROOT_STAGES-1:0] adv;
	logic [dqvcl_pkg::ROOT_STAGES-1:0] ones;

	dqvcl_pkg::root_state_t mag_q  [dqvcl_pkg::ROOT_STAGES];
	dqvcl_pkg::root_state_t qr_q   [dqvcl_pkg::ROOT_STAGES];
	dqvcl_pkg::side_t       side_q [dqvcl_pkg::ROOT_STAGES];
	dqvcl_pkg::root_state_t mag_in [dqvcl_pkg::ROOT_STAGES];
	dqvcl_pkg::root_state_t qr_in  [dqvcl_pkg::ROOT_STAGES];
	dqvcl_pkg::side_t       side_in[dqvcl_pkg::ROOT_STAGES];

	assign ones = '1;
	assign v_in = {v_q[dqvcl_pkg::ROOT_STAGES-2:0], in_valid};

	// a stage moves when the output is taken or some stage at or after it is empty
	always_comb begin
		for (int j = 0; j < dqvcl_pkg::ROOT_STAGES; j++) begin
			adv[j] = out_ready || ((v_q & (ones << j)) != (ones << j));
		end
	end

	always_comb begin
		mag_in[0]  = '{rad: in_data.sum, rem: '0, root: '0};
		qr_in[0]   = '{rad: in_data.diff, rem: '0, root: '0};
		side_in[0] = in_data.side;
		for (int j = 1; j < dqvcl_pkg::ROOT_STAGES; j++) begin
			mag_in[j]  = mag_q[j-1];
			qr_in[j]   = qr_q[j-1];
			side_in[j] = side_q[j-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			for (int j = 0; j < dqvcl_pkg::ROOT_STAGES; j++) begin
				if (adv[j]) begin
					v_q[j] <= v_in[j];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < dqvcl_pkg::ROOT_STAGES; j++) begin
			if (adv[j]) begin
				mag_q[j]  <= dqvcl_pkg::root_step(mag_in[j]);
				qr_q[j]   <= dqvcl_pkg::root_step(qr_in[j]);
				side_q[j] <= side_in[j];
			end
		end
	end

	assign in_ready  = adv[0];
	assign out_valid = v_q[dqvcl_pkg::ROOT_STAGES-1];
	assign out_data  = '{
		mag:   mag_q[dqvcl_pkg::ROOT_STAGES-1].root,
		qroot: qr_q[dqvcl_pkg::ROOT_STAGES-1].root,
		side:  side_q[dqvcl_pkg::ROOT_STAGES-1]
	};

endmodule

>>> hw/rtl/dq_voltage_circle_limiter_top.sv
// d/q voltage circle limiter: clamp, squares, twin root pipelines and result register
//
// Takes one d/q voltage request per cycle while nothing stalls, and returns one result per
// request, in order. The path has one clamp stage, one stage of squaring multipliers, one
// add and compare stage, CMP_WIDTH digit-recurrence stages that find the magnitude and
// the recomputed q side by side one root bit per stage, and the output register. Each
// stage holds while the stage after it is full and stalled, so bubbles close up and
// back-pressure reaches req.ready only when every stage is full.
// Register writes are meant for an empty pipeline.
module dq_voltage_circle_limiter_top (
	input  logic                                   clk,
	input  logic                                   arst_n,
	dqvcl_in_if.sink                               req,
	dqvcl_out_if.source                            rsp,
	input  logic                                   cfg_we,
	input  logic [dqvcl_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [dqvcl_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata
);

	logic signed [dqvcl_pkg::REG_WIDTH-1:0] torque_max_q;
	logic signed [dqvcl_pkg::REG_WIDTH-1:0] flux_min_q;
	logic [dqvcl_pkg::CIRCLE_WIDTH-1:0]     circle_max_q;

	logic adv1;
	logic adv2;
	logic adv3;
	logic adv_out;

	logic                                   v_s1;
	logic signed [dqvcl_pkg::CMP_WIDTH-1:0] qc_s1;
	logic signed [dqvcl_pkg::CMP_WIDTH-1:0] dc_s1;

	logic                                   v_s2;
	logic signed [dqvcl_pkg::CMP_WIDTH-1:0] qc_s2;
	logic [dqvcl_pkg::RAD_WIDTH-1:0]        q2_s2;
	logic [dqvcl_pkg::RAD_WIDTH-1:0]        d2_s2;
	logic [dqvcl_pkg::RAD_WIDTH-1:0]        c2_s2;

	logic                                   v_s3;
	dqvcl_pkg::root_in_t                    rin_s3;

	logic                                   rp_in_ready;
	logic                                   rp_valid;
	dqvcl_pkg::root_out_t                   rp_data;

	logic                                   out_valid_q;
	logic [dqvcl_pkg::VOLT_WIDTH-1:0]       q_limited_q;
	logic [dqvcl_pkg::VOLT_WIDTH-1:0]       magnitude_q;
	logic                                   circle_hit_q;

	logic signed [dqvcl_pkg::CMP_WIDTH-1:0] q_x;
	logic signed [dqvcl_pkg::CMP_WIDTH-1:0] d_x;
	logic signed [dqvcl_pkg::CMP_WIDTH-1:0] tmax_x;
	logic signed [dqvcl_pkg::CMP_WIDTH-1:0] fmin_x;
	logic signed [dqvcl_pkg::CMP_WIDTH-1:0] qc_nx;
	logic signed [dqvcl_pkg::CMP_WIDTH-1:0] dc_nx;
	logic signed [dqvcl_pkg::RAD_WIDTH-1:0] q2_full;
	logic signed [dqvcl_pkg::RAD_WIDTH-1:0] d2_full;
	logic [dqvcl_pkg::C2_WIDTH-1:0]         c2_full;
	logic                                   hit;
	logic [dqvcl_pkg::CMP_WIDTH-1:0]        q_sel;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			torque_max_q <= dqvcl_pkg::TORQUE_MAX_RESET;
			flux_min_q   <= dqvcl_pkg::FLUX_MIN_RESET;
			circle_max_q <= dqvcl_pkg::CIRCLE_MAX_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dqvcl_pkg::REG_TORQUE_MAX: torque_max_q <= cfg_wdata[dqvcl_pkg::REG_WIDTH-1:0];
				dqvcl_pkg::REG_FLUX_MIN:   flux_min_q   <= cfg_wdata[dqvcl_pkg::REG_WIDTH-1:0];
				dqvcl_pkg::REG_CIRCLE_MAX: circle_max_q <= cfg_wdata[dqvcl_pkg::CIRCLE_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// stall chain
	assign adv_out   = !out_valid_q || rsp.ready;
	assign adv3      = !v_s3 || rp_in_ready;
	assign adv2      = !v_s2 || adv3;
	assign adv1      = !v_s1 || adv2;
	assign req.ready = adv1;

	// stage 1: clamps
	always_comb begin
		q_x    = dqvcl_pkg::CMP_WIDTH'(req.volt_q);
		d_x    = dqvcl_pkg::CMP_WIDTH'(req.volt_d);
		tmax_x = dqvcl_pkg::CMP_WIDTH'(torque_max_q);
		fmin_x = dqvcl_pkg::CMP_WIDTH'(flux_min_q);
		qc_nx  = (q_x >= tmax_x) ? tmax_x : q_x;
		dc_nx  = (d_x <= fmin_x) ? fmin_x : d_x;
	end

	// stage 2: squares
	always_comb begin
		q2_full = qc_s1 * qc_s1;
		d2_full = dc_s1 * dc_s1;
		c2_full = circle_max_q * circle_max_q;
	end

	// output stage: circle decision
	always_comb begin
		hit   = rp_data.mag > dqvcl_pkg::CMP_WIDTH'(circle_max_q);
		q_sel = hit ? (rp_data.side.zero ? '0 : rp_data.qroot) : rp_data.side.qc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= req.valid;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
			if (adv3) begin
				v_s3 <= v_s2;
			end
			if (adv_out) begin
				out_valid_q <= rp_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			qc_s1 <= qc_nx;
			dc_s1 <= dc_nx;
		end
		if (adv2) begin
			qc_s2 <= qc_s1;
			q2_s2 <= q2_full;
			d2_s2 <= d2_full;
			c2_s2 <= dqvcl_pkg::RAD_WIDTH'(c2_full);
		end
		if (adv3) begin
			rin_s3.sum       <= q2_s2 + d2_s2;
			rin_s3.diff      <= c2_s2 - d2_s2;
			rin_s3.side.qc   <= qc_s2;
			rin_s3.side.zero <= d2_s2 >= c2_s2;
		end
		if (adv_out) begin
			q_limited_q  <= q_sel[dqvcl_pkg::VOLT_WIDTH-1:0];
			magnitude_q  <= rp_data.mag[dqvcl_pkg::VOLT_WIDTH-1:0];
			circle_hit_q <= hit;
		end
	end

	dqvcl_root_pipe u_root (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.in_ready  (rp_in_ready),
		.in_data   (rin_s3),
		.out_valid (rp_valid),
		.out_ready (adv_out),
		.out_data  (rp_data)
	);

	assign rsp.valid      = out_valid_q;
	assign rsp.q_limited  = q_limited_q;
	assign rsp.magnitude  = magnitude_q;
	assign rsp.circle_hit = circle_hit_q;

	// first stage fills only from an accepted request
	a_s1_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(v_s1) |-> $past(req.valid && req.ready))
		else $error("stage 1 filled without a request");

	// a blocked first stage keeps its contents
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !adv2 |=> v_s1 && $stable(qc_s1) && $stable(dc_s1))
		else $error("stage 1 lost data under stall");

	// result register fills only from the root pipeline
	a_out_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(rp_valid))
		else $error("result appeared without a root pipeline result");

	// a circle hit needs a nonzero magnitude
	a_hit_mag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.circle_hit |-> rsp.magnitude != '0)
		else $error("circle hit with zero magnitude");

endmodule

>>> tb/tb.sv
// testbench for the d/q voltage circle limiter: directed table, random phases, scoreboard
`timescale 1ns / 100ps

module tb;
	import dqvcl_pkg::*;

	localparam logic signed [VOLT_WIDTH-1:0] RST_TORQUE = 16'sd200;
	localparam logic signed [VOLT_WIDTH-1:0] RST_FLUX   = -16'sd5;
	localparam logic [CIRCLE_WIDTH-1:0]      RST_RADIUS = 15'd200;
	localparam logic [CFG_INDEX_WIDTH-1:0]   REG_SPARE  = 2'd3;
	localparam int DRAIN_CYCLES    = 24;
	localparam int STUCK_LIMIT     = 4000;
	localparam int RAND_PHASES     = 8;
	localparam int ITEMS_PER_PHASE = 212;
	localparam int PLAN_ROWS       = 24;

	typedef struct packed {
		logic signed [VOLT_WIDTH-1:0] q_lim;
		logic [VOLT_WIDTH-1:0]        mag;
		logic                         hit;
	} limit_result_t;

	typedef enum logic [1:0] {ROW_REQ, ROW_REQ_KNOWN, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t       kind;
		logic [15:0]     a;
		logic [15:0]     b;
		limit_result_t   want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index;
	logic [CFG_DATA_WIDTH-1:0]  cfg_wdata;

	dqvcl_in_if  req_ch();
	dqvcl_out_if rsp_ch();

	dq_voltage_circle_limiter_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	logic signed [VOLT_WIDTH-1:0] lim_torque_max = RST_TORQUE;
	logic signed [VOLT_WIDTH-1:0] lim_flux_min   = RST_FLUX;
	logic [CIRCLE_WIDTH-1:0]      lim_circle_max = RST_RADIUS;

	limit_result_t pending_limits[$];
	int  fail_count   = 0;
	int  stuck_cycles = 0;
	int  rx_stall     = 0;
	bit  tx_steady    = 1'b0;
	bit  rx_steady    = 1'b0;

	// columns: kind, q or register index, d or write data, expected result where obvious
	stim_row_t plan [PLAN_ROWS] = '{
		'{ROW_REQ_KNOWN, 16'sd0,       16'sd0,       '{16'sd0,    16'd0,     1'b0}},
		'{ROW_REQ_KNOWN, 16'sh7fff,    16'sh8000,    '{16'sd200,  16'd200,   1'b0}},
		'{ROW_REQ_KNOWN, 16'sh8000,    16'sh7fff,    '{16'sd0,    16'd46340, 1'b1}},
		'{ROW_REQ_KNOWN, 16'sd200,     -16'sd5,      '{16'sd200,  16'd200,   1'b0}},
		'{ROW_REQ,       16'sd100,     16'sd180,     '0},
		'{ROW_REQ,       -16'sd150,    -16'sd5,      '0},
		'{ROW_WRITE,     16'(REG_TORQUE_MAX), -16'sd100, '0},
		'{ROW_WRITE,     16'(REG_FLUX_MIN),   16'sh8000, '0},
		'{ROW_WRITE,     16'(REG_CIRCLE_MAX), 16'sh7fff, '0},
		'{ROW_REQ_KNOWN, 16'sd0,       16'sd0,       '{-16'sd100, 16'd100,   1'b0}},
		'{ROW_REQ_KNOWN, 16'sh8000,    16'sh8000,    '{16'sd0,    16'd46340, 1'b1}},
		'{ROW_REQ,       -16'sd100,    16'sh7fff,    '0},
		'{ROW_WRITE,     16'(REG_CIRCLE_MAX), 16'sh8000, '0},
		'{ROW_REQ,       16'sh8000,    16'sd0,       '0},
		'{ROW_REQ,       16'sh8000,    16'sd1,       '0},
		'{ROW_REQ,       -16'sd1,      16'sh7fff,    '0},
		'{ROW_WRITE,     16'(REG_SPARE),      16'sh1234, '0},
		'{ROW_REQ,       16'sd5,       16'sd5,       '0},
		'{ROW_WRITE,     16'(REG_TORQUE_MAX), 16'sh7fff, '0},
		'{ROW_WRITE,     16'(REG_FLUX_MIN),   16'sh7fff, '0},
		'{ROW_WRITE,     16'(REG_CIRCLE_MAX), 16'shffff, '0},
		'{ROW_REQ,       16'sh7fff,    16'sh8000,    '0},
		'{ROW_REQ,       16'sh8000,    16'sh7fff,    '0},
		'{ROW_REQ,       16'sh5555,    16'shaaaa,    '0}
	};

	always #1 clk = ~clk;

	function automatic int idle_span();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	function automatic longint floor_root(input longint x);
		longint r;
		longint t;
		r = 0;
		for (int b = 16; b >= 0; b--) begin
			t = r | (longint'(1) << b);
			if (t * t <= x)
				r = t;
		end
		return r;
	endfunction

	function automatic limit_result_t limit_dq(input logic signed [VOLT_WIDTH-1:0] vq,
		input logic signed [VOLT_WIDTH-1:0] vd);
		longint q;
		longint d;
		longint d2;
		longint c2;
		longint mag;
		limit_result_t r;
		q = vq;
		d = vd;
		if (q >= lim_torque_max)
			q = lim_torque_max;
		if (d <= lim_flux_min)
			d = lim_flux_min;
		d2 = d * d;
		mag = floor_root(d2 + q * q);
		c2 = longint'(lim_circle_max) * longint'(lim_circle_max);
		r.mag = VOLT_WIDTH'(mag);
		r.hit = mag > longint'(lim_circle_max);
		if (!r.hit)
			r.q_lim = VOLT_WIDTH'(q);
		else if (d2 >= c2)
			r.q_lim = '0;
		else
			r.q_lim = VOLT_WIDTH'(floor_root(c2 - d2));
		return r;
	endfunction

	function automatic logic [15:0] reg_pick(input bit radius);
		logic [15:0] v;
		case ($urandom_range(0, 4))
			0: v = radius ? 16'h0000 : 16'h8000;
			1: v = 16'h7fff;
			2: v = 16'($urandom());
			default: v = radius ? 16'($urandom_range(0, 600)) : 16'($urandom_range(0, 800) - 400);
		endcase
		if (radius)
			v[15] = $urandom_range(0, 1);
		return v;
	endfunction

	function automatic logic [VOLT_WIDTH-1:0] near_value(input int reach);
		int v;
		v = int'($urandom_range(0, 2 * reach)) - reach;
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return VOLT_WIDTH'(v);
	endfunction

	task automatic send_request(input logic signed [VOLT_WIDTH-1:0] q,
		input logic signed [VOLT_WIDTH-1:0] d, input logic known, input limit_result_t want);
		int gap;
		req_ch.volt_q <= q;
		req_ch.volt_d <= d;
		req_ch.valid  <= 1'b1;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		pending_limits.push_back(known ? want : limit_dq(q, d));
		gap = tx_steady ? 0 : idle_span();
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic settle_pipeline();
		req_ch.valid <= 1'b0;
		while (pending_limits.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_limit_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
		input logic [CFG_DATA_WIDTH-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_TORQUE_MAX: lim_torque_max = data;
			REG_FLUX_MIN:   lim_flux_min = data;
			REG_CIRCLE_MAX: lim_circle_max = data[CIRCLE_WIDTH-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else if (rx_stall != 0) begin
			rx_stall     <= rx_stall - 1;
			rsp_ch.ready <= 1'b0;
		end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
			rx_stall     <= idle_span();
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		limit_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_limits.size() == 0) begin
				$error("result with no request outstanding: q_limited %0d magnitude %0d",
					rsp_ch.q_limited, rsp_ch.magnitude);
				fail_count++;
			end else begin
				want = pending_limits.pop_front();
				if (rsp_ch.q_limited !== want.q_lim) begin
					$error("q_limited: expected %0d, got %0d", want.q_lim, rsp_ch.q_limited);
					fail_count++;
				end
				if (rsp_ch.magnitude !== want.mag) begin
					$error("magnitude: expected %0d, got %0d", want.mag, rsp_ch.magnitude);
					fail_count++;
				end
				if (rsp_ch.circle_hit !== want.hit) begin
					$error("circle_hit: expected %0d, got %0d", want.hit, rsp_ch.circle_hit);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles == STUCK_LIMIT) begin
			$display("tb: errors");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	initial begin
		logic signed [VOLT_WIDTH-1:0] q;
		logic signed [VOLT_WIDTH-1:0] d;
		int reach;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_wdata     = '0;
		req_ch.valid  = 1'b0;
		req_ch.volt_q = '0;
		req_ch.volt_d = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_WRITE) begin
				settle_pipeline();
				write_limit_reg(plan[i].a[CFG_INDEX_WIDTH-1:0], plan[i].b);
			end else begin
				send_request(plan[i].a, plan[i].b, plan[i].kind == ROW_REQ_KNOWN, plan[i].want);
			end
		end

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			settle_pipeline();
			write_limit_reg(REG_TORQUE_MAX, reg_pick(1'b0));
			write_limit_reg(REG_FLUX_MIN, reg_pick(1'b0));
			write_limit_reg(REG_CIRCLE_MAX, reg_pick(1'b1));
			if ($urandom_range(0, 2) == 0)
				write_limit_reg(REG_SPARE, 16'($urandom()));
			tx_steady = ($urandom_range(0, 3) == 0);
			rx_steady = ($urandom_range(0, 3) == 0);
			reach = int'(lim_circle_max) + 64;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if ($urandom_range(0, 149) == 0)
					settle_pipeline();
				case ($urandom_range(0, 3))
					0: begin
						q = 16'($urandom());
						d = 16'($urandom());
					end
					3: begin
						q = $urandom_range(0, 1) ? lim_torque_max : near_value(reach);
						d = $urandom_range(0, 1) ? lim_flux_min : near_value(reach);
					end
					default: begin
						q = near_value(reach);
						d = near_value(reach);
					end
				endcase
				send_request(q, d, 1'b0, '0);
			end
		end

		req_ch.valid <= 1'b0;
		while (pending_limits.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
